// ===== sv/cb64_pkg.sv =====
// ----------------------------------------------------------------------------
// cb64_pkg: shared types and constants for the checksummed base64 encoder
// Holds the group job passed from front to back, the base64 alphabet and
// the fixed character codes.
// ----------------------------------------------------------------------------
package cb64_pkg;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] TERM_RESET = 8'hFF;

  // One encoding job: up to three bytes packed MSB first, the number of real
  // bytes (1..3), and whether the frame terminator follows the group.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        term;
  } cb64_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cb64_qstat_t;

  function automatic logic [7:0] b64_char(input logic [5:0] sextet);
    logic [7:0] c;
    if (sextet < 6'd26) begin
      c = 8'h41 + {2'b00, sextet};
    end else if (sextet < 6'd52) begin
      c = 8'h61 + {2'b00, sextet - 6'd26};
    end else if (sextet < 6'd62) begin
      c = 8'h30 + {2'b00, sextet - 6'd52};
    end else if (sextet == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== sv/cb64_front.sv =====
// ----------------------------------------------------------------------------
// cb64_front: byte intake, checksum and grouping
// Accumulates bytes into three-byte groups, keeps the running sum and issues
// one job per finished group; the checksum group goes out from the pend
// register after the last byte, once the queue has room.
// ----------------------------------------------------------------------------
module cb64_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 full,
  input  cb64_pkg::cb64_qstat_t qstat,
  output logic                 job_push,
  output cb64_pkg::cb64_job_t  job
);

  logic [7:0]  running_sum;
  logic [15:0] group_bytes;
  logic [1:0]  group_count;
  logic        pend;
  logic        accept;
  logic [7:0]  sum_add;
  logic        sum_go;

  assign full    = pend | qstat.full;
  assign accept  = push & ~full;
  assign sum_add = running_sum + data_byte;
  assign sum_go  = pend & ~qstat.full;

  always_comb begin
    job = '0;
    if (pend) begin
      // checksum byte closes the frame, with whatever bytes are pending
      job.term = 1'b1;
      case (group_count)
        2'd2: begin
          job.word   = {group_bytes, running_sum};
          job.nbytes = 2'd3;
        end
        2'd1: begin
          job.word   = {group_bytes[15:8], running_sum, 8'h00};
          job.nbytes = 2'd2;
        end
        default: begin
          job.word   = {running_sum, 16'h0000};
          job.nbytes = 2'd1;
        end
      endcase
      job_push = sum_go;
    end else begin
      job.word   = {group_bytes, data_byte};
      job.nbytes = 2'd3;
      job.term   = 1'b0;
      job_push   = accept & (group_count == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= 1'b0;
      running_sum <= '0;
      group_bytes <= '0;
      group_count <= '0;
    end else if (sum_go) begin
      pend        <= 1'b0;
      running_sum <= '0;
      group_bytes <= '0;
      group_count <= '0;
    end else if (accept) begin
      running_sum <= sum_add;
      case (group_count)
        2'd2: begin
          group_count <= 2'd0;
        end
        2'd1: begin
          group_bytes[7:0] <= data_byte;
          group_count      <= 2'd2;
        end
        default: begin
          group_bytes <= {data_byte, 8'h00};
          group_count <= 2'd1;
        end
      endcase
      if (last_byte) begin
        pend <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/cb64_queue.sv =====
// ----------------------------------------------------------------------------
// cb64_queue: job queue between front and back
// Small circular buffer of group jobs with simultaneous push and pop.
// ----------------------------------------------------------------------------
module cb64_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  cb64_pkg::cb64_job_t   wr_job,
  input  logic                  rd,
  output cb64_pkg::cb64_job_t   rd_job,
  output cb64_pkg::cb64_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cb64_pkg::cb64_job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign do_wr       = wr & ~qstat.full;
  assign do_rd       = rd & ~qstat.empty;
  assign rd_job      = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/cb64_back.sv =====
// ----------------------------------------------------------------------------
// cb64_back: character serializer
// Walks each job, one character a cycle unless stalled, into an output
// register: four base64 or pad characters, then a closing job's terminator.
// ----------------------------------------------------------------------------
module cb64_back (
  input  logic                  clk,
  input  logic                  rst,
  input  cb64_pkg::cb64_job_t   job,
  input  cb64_pkg::cb64_qstat_t qstat,
  output logic                  job_pop,
  input  logic [7:0]            terminator_byte,
  input  logic                  pop,
  output logic                  empty,
  output logic [7:0]            out_char,
  output logic                  frame_end
);

  logic       out_valid;
  logic [2:0] idx;
  logic       advance;
  logic       at_term;
  logic       done;
  logic [5:0] sextet;
  logic [7:0] char_next;

  assign empty   = ~out_valid;
  assign advance = ~qstat.empty & (~out_valid | pop);
  assign at_term = (idx == 3'd4);
  assign done    = job.term ? at_term : (idx == 3'd3);
  assign job_pop = advance & done;

  always_comb begin
    case (idx[1:0])
      2'd0:    sextet = job.word[23:18];
      2'd1:    sextet = job.word[17:12];
      2'd2:    sextet = job.word[11:6];
      default: sextet = job.word[5:0];
    endcase
    if (at_term) begin
      char_next = terminator_byte;
    end else if (idx <= {1'b0, job.nbytes}) begin
      char_next = cb64_pkg::b64_char(sextet);
    end else begin
      char_next = cb64_pkg::CHAR_PAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      idx       <= done ? 3'd0 : idx + 3'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char  <= char_next;
      frame_end <= at_term;
    end
  end

endmodule

// ===== sv/checksummed_base64_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// checksummed_base64_frame_encoder: base64 framer with additive checksum
// Takes message bytes, appends their modulo-256 sum, base64-encodes the lot
// and closes each frame with a programmable terminator byte.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  --------  ------------------------  ---------------------------
//  input     push / full               data_byte, last_byte
//  result    pop / empty               out_char, frame_end
//  config    cfg_valid / cfg_ready     cfg_data (terminator byte)
//
// The front takes one byte a cycle while full is low; a last byte holds full
// while the checksum group is queued. The back sends one character a cycle
// while the output slot is free or popped: four per three-byte group, five
// for the closing group, so the back serializer sets the sustained rate.
// Reset is synchronous: queue and output slot empty, sums cleared,
// terminator back to 0xFF. A stalled pop holds the output slot; the queue
// lets the front keep taking bytes until it fills.
// ----------------------------------------------------------------------------
module checksummed_base64_frame_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_char,
  output logic       frame_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0]            terminator_byte;
  logic                  job_push;
  logic                  job_pop;
  cb64_pkg::cb64_job_t   front_job;
  cb64_pkg::cb64_job_t   head_job;
  cb64_pkg::cb64_qstat_t qstat;

  // Config requests are always taken; the user must send them only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminator_byte <= cb64_pkg::TERM_RESET;
    end else if (cfg_valid) begin
      terminator_byte <= cfg_data;
    end
  end

  // Front: take bytes, keep the sum, build three-byte groups.
  cb64_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .full      (full),
    .qstat     (qstat),
    .job_push  (job_push),
    .job       (front_job)
  );

  // Queue: decouple group building from character output.
  cb64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_job (front_job),
    .rd     (job_pop),
    .rd_job (head_job),
    .qstat  (qstat)
  );

  // Back: advance one character per cycle into the output slot while it can take one.
  cb64_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job             (head_job),
    .qstat           (qstat),
    .job_pop         (job_pop),
    .terminator_byte (terminator_byte),
    .pop             (pop),
    .empty           (empty),
    .out_char        (out_char),
    .frame_end       (frame_end)
  );

`ifndef SYNTHESIS
  // A last byte blocks intake for the checksum cycle.
  assert property (@(posedge clk) disable iff (rst)
    push && !full && last_byte |=> full)
    else $error("full not raised after last byte");

  // The frame-closing result carries the programmed terminator.
  assert property (@(posedge clk) disable iff (rst)
    !empty && frame_end |-> out_char == terminator_byte)
    else $error("frame_end without terminator byte");

  // Nothing waits on the result side right after reset.
  assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");
`endif

endmodule
